// File: rtl/prflru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prflru_pkg;

    // Build defaults
    localparam int DEF_NUM_WAYS    = 8;
    localparam int DEF_COUNT_WIDTH = 16;

    // Field widths
    localparam int OP_W         = 1;
    localparam int PAGE_W       = 8;
    localparam int SLOT_FIELD_W = 3;
    localparam int CNT_FIELD_W  = 16;
    localparam int IN_TDATA_W   = 8;
    localparam int IN_TUSER_W   = 1;
    localparam int OUT_TDATA_W  = 48;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int WAYS_CFG_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_IN_USE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLICY_MODE = 1'b1;

    localparam logic [WAYS_CFG_W-1:0] WAYS_RESET = 4'd8;

    // Operation and policy codes
    localparam logic OP_REF   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic POL_FIFO = 1'b0;
    localparam logic POL_LRU  = 1'b1;

    // Index width for a set of n entries, at least one bit
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

// File: rtl/prflru_lru_pick.sv
`timescale 1ns / 1ps
`default_nettype none

// Pick the oldest slot in use; ties go to the lowest slot number.
module prflru_lru_pick #(
    parameter int  NUM_WAYS = prflru_pkg::DEF_NUM_WAYS,
    localparam int AGE_W    = prflru_pkg::idx_w(NUM_WAYS),
    localparam int WAY_W    = prflru_pkg::idx_w(NUM_WAYS)
) (
    input  wire logic [NUM_WAYS-1:0][AGE_W-1:0] i_age,
    input  wire logic [NUM_WAYS-1:0]            i_in_use,
    output logic      [WAY_W-1:0]               o_idx
);

    logic [NUM_WAYS-1:0] beaten;

    // Pairwise compare: a slot loses to an earlier one of equal or greater age
    // or to a later one of strictly greater age.
    always_comb begin
        for (int i = 0; i < NUM_WAYS; i++) begin
            beaten[i] = !i_in_use[i];
            for (int j = 0; j < NUM_WAYS; j++) begin
                if (j < i && i_in_use[j] && (i_age[j] >= i_age[i])) begin
                    beaten[i] = 1'b1;
                end
                if (j > i && i_in_use[j] && (i_age[j] > i_age[i])) begin
                    beaten[i] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_idx = '0;
        for (int i = NUM_WAYS - 1; i >= 0; i--) begin
            if (!beaten[i]) begin
                o_idx = WAY_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/page_replacement_fifo_lru_top.sv
// Path: an accepted transaction passes through the input register, then the result register.
// Throughput: one reference per cycle unless m_axis stalls; tag match, victim pick and
//   age update all sit between the input register and the result register.
// Reset (i_rst_n low, synchronous): all slots empty, ages, FIFO pointer and hit/miss
//   counts zero, ways_in_use 8, policy LRU. Page tags are not reset.
`timescale 1ns / 1ps
`default_nettype none

module page_replacement_fifo_lru_top #(
    parameter int NUM_WAYS    = prflru_pkg::DEF_NUM_WAYS,
    parameter int COUNT_WIDTH = prflru_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [prflru_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [prflru_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // reference stream in
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [prflru_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] page
    input  wire logic [prflru_pkg::IN_TUSER_W-1:0]  s_axis_tuser,   // [0] op
    // result stream out
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [0] hit, [3:1] slot, [4] evicted_valid, [12:5] evicted_page,
    // [28:13] hit_count, [44:29] miss_count, [47:45] zero
    output logic [prflru_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    import prflru_pkg::*;

    localparam int WAY_W = idx_w(NUM_WAYS);
    localparam int AGE_W = idx_w(NUM_WAYS);
    // wide enough for NUM_WAYS itself and for the 4-bit ways register
    localparam int CMP_W = ($clog2(NUM_WAYS + 1) > WAYS_CFG_W) ?
                           $clog2(NUM_WAYS + 1) : WAYS_CFG_W;
    localparam logic [AGE_W-1:0]       AGE_MAX   = AGE_W'(NUM_WAYS - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WAYS_CFG_W-1:0] r_ways_in_use;
    logic                  r_policy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways_in_use <= WAYS_RESET;
            r_policy      <= POL_LRU;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WAYS_IN_USE: r_ways_in_use <= i_cfg_data[WAYS_CFG_W-1:0];
                CFG_POLICY_MODE: r_policy      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register: hold one transaction until the result register frees up
    // ------------------------------------------------------------------
    logic              r_in_vld;
    logic              r_in_op;
    logic [PAGE_W-1:0] r_in_page;
    logic              r_out_vld;
    logic              w_advance;

    assign w_advance     = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser[0];
            r_in_page <= s_axis_tdata[PAGE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Page store state
    // ------------------------------------------------------------------
    logic [PAGE_W-1:0]               r_page [NUM_WAYS];
    logic [NUM_WAYS-1:0]             r_valid;
    logic [NUM_WAYS-1:0][AGE_W-1:0]  r_age;
    logic [WAY_W-1:0]                r_fifo_ptr;
    logic [COUNT_WIDTH-1:0]          r_hits;
    logic [COUNT_WIDTH-1:0]          r_misses;

    // ------------------------------------------------------------------
    // Lookup and replacement decision
    // ------------------------------------------------------------------
    logic [CMP_W-1:0]               w_ways;
    logic [CMP_W-1:0]               w_ways_raw;
    logic [NUM_WAYS-1:0]            w_in_use;
    logic [NUM_WAYS-1:0]            w_match;
    logic [NUM_WAYS-1:0]            w_empty;
    logic                           w_hit;
    logic                           w_has_empty;
    logic [WAY_W-1:0]               w_hit_idx;
    logic [WAY_W-1:0]               w_empty_idx;
    logic [WAY_W-1:0]               w_fifo_idx;
    logic [WAY_W-1:0]               w_fifo_next;
    logic [CMP_W-1:0]               w_fifo_inc;
    logic [WAY_W-1:0]               w_lru_idx;
    logic [WAY_W-1:0]               w_slot;
    logic                           w_was_valid;
    logic                           w_evict;
    logic                           w_fifo_step;
    logic [NUM_WAYS-1:0][AGE_W-1:0] n_age;
    logic [COUNT_WIDTH-1:0]         n_hits;
    logic [COUNT_WIDTH-1:0]         n_misses;

    // Clamp ways in use to 1..NUM_WAYS
    always_comb begin
        w_ways_raw = CMP_W'(r_ways_in_use);
        if (w_ways_raw == '0) begin
            w_ways = CMP_W'(1);
        end else if (w_ways_raw > CMP_W'(NUM_WAYS)) begin
            w_ways = CMP_W'(NUM_WAYS);
        end else begin
            w_ways = w_ways_raw;
        end
    end

    // Tag compare across all slots; lowest matching / lowest empty slot wins
    always_comb begin
        w_hit_idx   = '0;
        w_empty_idx = '0;
        for (int i = 0; i < NUM_WAYS; i++) begin
            w_in_use[i] = CMP_W'(i) < w_ways;
            w_match[i]  = w_in_use[i] && r_valid[i] && (r_page[i] == r_in_page);
            w_empty[i]  = w_in_use[i] && !r_valid[i];
        end
        for (int i = NUM_WAYS - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_hit_idx = WAY_W'(i);
            end
            if (w_empty[i]) begin
                w_empty_idx = WAY_W'(i);
            end
        end
        w_hit       = |w_match;
        w_has_empty = |w_empty;
    end

    // FIFO slot: a pointer beyond the ways in use falls back to slot 0
    always_comb begin
        w_fifo_idx  = (CMP_W'(r_fifo_ptr) < w_ways) ? r_fifo_ptr : '0;
        w_fifo_inc  = CMP_W'(w_fifo_idx) + CMP_W'(1);
        w_fifo_next = (w_fifo_inc == w_ways) ? '0 : w_fifo_inc[WAY_W-1:0];
    end

    prflru_lru_pick #(
        .NUM_WAYS (NUM_WAYS)
    ) u_lru_pick (
        .i_age    (r_age),
        .i_in_use (w_in_use),
        .o_idx    (w_lru_idx)
    );

    always_comb begin
        w_evict     = !w_hit && !w_has_empty;
        w_fifo_step = w_evict && (r_policy == POL_FIFO);
        w_was_valid = !(!w_hit && w_has_empty);

        if (w_hit) begin
            w_slot = w_hit_idx;
        end else if (w_has_empty) begin
            w_slot = w_empty_idx;
        end else if (r_policy == POL_FIFO) begin
            w_slot = w_fifo_idx;
        end else begin
            w_slot = w_lru_idx;
        end
    end

    // Recency update: the touched slot becomes age 0; valid slots newer than it
    // (all valid slots, on a fill) age by one and stop at the maximum.
    always_comb begin
        for (int i = 0; i < NUM_WAYS; i++) begin
            n_age[i] = r_age[i];
            if (WAY_W'(i) == w_slot) begin
                n_age[i] = '0;
            end else if (w_in_use[i] && r_valid[i] &&
                         (!w_was_valid || (r_age[i] < r_age[w_slot])) &&
                         (r_age[i] != AGE_MAX)) begin
                n_age[i] = r_age[i] + AGE_W'(1);
            end
        end
    end

    // Saturating totals
    always_comb begin
        n_hits   = r_hits;
        n_misses = r_misses;
        if (w_hit) begin
            if (r_hits != COUNT_MAX) begin
                n_hits = r_hits + COUNT_WIDTH'(1);
            end
        end else if (r_misses != COUNT_MAX) begin
            n_misses = r_misses + COUNT_WIDTH'(1);
        end
    end

    // ------------------------------------------------------------------
    // State update: commit on each advancing transaction
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_age      <= '0;
            r_fifo_ptr <= '0;
            r_hits     <= '0;
            r_misses   <= '0;
        end else if (w_advance) begin
            if (r_in_op == OP_CLEAR) begin
                r_valid    <= '0;
                r_age      <= '0;
                r_fifo_ptr <= '0;
                r_hits     <= '0;
                r_misses   <= '0;
            end else begin
                r_valid[w_slot] <= 1'b1;
                r_age           <= n_age;
                r_hits          <= n_hits;
                r_misses        <= n_misses;
                if (w_fifo_step) begin
                    r_fifo_ptr <= w_fifo_next;
                end
            end
        end
    end

    // Tag write on a miss (fill or replace)
    always_ff @(posedge i_clk) begin
        if (w_advance && (r_in_op == OP_REF) && !w_hit) begin
            r_page[w_slot] <= r_in_page;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                    r_out_hit;
    logic [SLOT_FIELD_W-1:0] r_out_slot;
    logic                    r_out_ev;
    logic [PAGE_W-1:0]       r_out_ev_page;
    logic [CNT_FIELD_W-1:0]  r_out_hits;
    logic [CNT_FIELD_W-1:0]  r_out_misses;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            if (r_in_op == OP_CLEAR) begin
                r_out_hit     <= 1'b0;
                r_out_slot    <= '0;
                r_out_ev      <= 1'b0;
                r_out_ev_page <= '0;
                r_out_hits    <= '0;
                r_out_misses  <= '0;
            end else begin
                r_out_hit     <= w_hit;
                r_out_slot    <= SLOT_FIELD_W'(w_slot);
                r_out_ev      <= w_evict;
                r_out_ev_page <= w_evict ? r_page[w_slot] : '0;
                r_out_hits    <= CNT_FIELD_W'(n_hits);
                r_out_misses  <= CNT_FIELD_W'(n_misses);
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'b000, r_out_misses, r_out_hits, r_out_ev_page,
                            r_out_ev, r_out_slot, r_out_hit};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A clear empties the store and zeroes both totals
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_in_op == OP_CLEAR)) |=>
            (r_valid == '0) && (r_hits == '0) && (r_misses == '0))
        else $error("clear did not empty the store");

    // A hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(r_out_hit && r_out_ev))
        else $error("hit reported with eviction");

    // The slot a reference lands in is valid afterwards
    a_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_in_op == OP_REF)) |=> r_valid[$past(w_slot)])
        else $error("referenced slot not valid");

    // A reference that finds an empty slot never evicts
    a_fill_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_in_op == OP_REF) && w_has_empty) |=> !r_out_ev)
        else $error("eviction while an empty slot was free");

endmodule

`default_nettype wire
